// ===== sv/mmwat_pkg.sv =====
// Package: shared types and constants of the min/max weighted average tracker.
`default_nettype none

package mmwat_pkg;

  // Width of the minimum, maximum and average result fields.
  localparam int OUT_WIDTH = 16;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted request
    logic mul;     // register |sample - average| * elapsed
    logic prep;    // seed the divider remainder and step counter
    logic step;    // one restoring division step
    logic finish;  // commit state and load the result registers
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic blend;     // the weighted formula applies to the held request
    logic div_last;  // the current division step is the last one
  } status_t;

endpackage

`default_nettype wire

// ===== sv/min_max_weighted_average_tracker.sv =====
// When the weighted formula applies, a request passes through one multiply, one divider
// seed, VALUE_WIDTH restoring steps and a commit; otherwise through the multiply and the
// commit. The bit-serial divider takes one request at a time: a new request is accepted
// only after the current one commits, and the commit waits while a held result stalls.
// The result register lets a new request enter while the previous result waits.
// Reset (rst, synchronous): clears minimum, maximum, average and output valid.
`default_nettype none

module min_max_weighted_average_tracker
  import mmwat_pkg::*;
#(
  parameter int VALUE_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Request channel.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_WIDTH-1:0] sample_value,
  input  wire logic [TIME_WIDTH-1:0]  elapsed_time,
  input  wire logic [TIME_WIDTH-1:0]  total_residency,
  // Result channel.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [OUT_WIDTH-1:0]        minimum_seen,
  output logic [OUT_WIDTH-1:0]        maximum_seen,
  output logic [OUT_WIDTH-1:0]        weighted_average,
  output logic                        average_saturated
);

  cmd_t    cmd;
  status_t status;

  // Sequence the request: hold off new requests until the current one commits.
  mmwat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Compute avg + (s-avg)*e/r as a product followed by a bit-serial quotient;
  // the quotient is never above |s-avg|, so VALUE_WIDTH bits suffice.
  mmwat_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .sample_value      (sample_value),
    .elapsed_time      (elapsed_time),
    .total_residency   (total_residency),
    .minimum_seen      (minimum_seen),
    .maximum_seen      (maximum_seen),
    .weighted_average  (weighted_average),
    .average_saturated (average_saturated)
  );

endmodule

`default_nettype wire

// ===== sv/mmwat_ctrl.sv =====
// Controller: sequences one request through multiply, an optional divide and commit.
`default_nettype none

module mmwat_ctrl
  import mmwat_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.blend ? S_PREP : S_FIN;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // Commit only when the result register is free or drains now.
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mmwat_dpath.sv =====
// Datapath: running state, product register, restoring divider, result registers.
`default_nettype none

module mmwat_dpath
  import mmwat_pkg::*;
#(
  parameter int VALUE_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  input  wire logic [VALUE_WIDTH-1:0] sample_value,
  input  wire logic [TIME_WIDTH-1:0]  elapsed_time,
  input  wire logic [TIME_WIDTH-1:0]  total_residency,
  output logic [OUT_WIDTH-1:0]        minimum_seen,
  output logic [OUT_WIDTH-1:0]        maximum_seen,
  output logic [OUT_WIDTH-1:0]        weighted_average,
  output logic                        average_saturated
);

  localparam int PW = VALUE_WIDTH + TIME_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
  localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_WIDTH - 1);

  // Held request.
  logic [VALUE_WIDTH-1:0] smp;
  logic [TIME_WIDTH-1:0]  etm;
  logic [TIME_WIDTH-1:0]  res;

  // Running state.
  logic [VALUE_WIDTH-1:0] mn;
  logic [VALUE_WIDTH-1:0] mx;
  logic [VALUE_WIDTH-1:0] avg;
  logic [VALUE_WIDTH-1:0] mn_next;
  logic [VALUE_WIDTH-1:0] mx_next;
  logic [VALUE_WIDTH-1:0] avg_next;
  logic                   sat_next;

  // Multiplier and divider.
  logic                   up;
  logic [VALUE_WIDTH-1:0] diff;
  logic [PW-1:0]          prod;
  logic [TIME_WIDTH-1:0]  rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] prod_lo;
  logic [TIME_WIDTH:0]    trial;
  logic                   fits;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH:0]   dec;

  assign up      = smp >= avg;
  assign diff    = up ? (smp - avg) : (avg - smp);
  assign prod_lo = prod[VALUE_WIDTH-1:0];
  assign trial   = {rem, prod_lo[cnt]};
  assign fits    = trial >= {1'b0, res};

  assign status.blend    = (smp != '0) && (res > etm) && (avg != '0);
  assign status.div_last = (cnt == '0);

  always_comb begin
    mn_next  = mn;
    mx_next  = mx;
    avg_next = avg;
    sat_next = 1'b0;
    sum      = {1'b0, avg} + {1'b0, quo};
    dec      = {1'b0, quo} + (VALUE_WIDTH+1)'(rem != '0);
    if (smp != '0) begin
      if (smp > mx) begin
        mx_next = smp;
      end
      if (smp < mn || mn == '0) begin
        mn_next = smp;
      end
      if (status.blend) begin
        if (up) begin
          if (sum[VALUE_WIDTH]) begin
            avg_next = VALUE_MAX;
            sat_next = 1'b1;
          end else begin
            avg_next = sum[VALUE_WIDTH-1:0];
          end
        end else begin
          // Round the downward step up so the result is the floor.
          avg_next = avg - dec[VALUE_WIDTH-1:0];
        end
      end else begin
        avg_next = smp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mn  <= '0;
      mx  <= '0;
      avg <= '0;
    end else if (cmd.finish) begin
      mn  <= mn_next;
      mx  <= mx_next;
      avg <= avg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= sample_value;
      etm <= elapsed_time;
      res <= total_residency;
    end
    if (cmd.mul) begin
      prod <= PW'(diff) * PW'(etm);
    end
    if (cmd.prep) begin
      // The product is below divisor * 2^VALUE_WIDTH, so the top part is a valid remainder.
      rem <= prod[PW-1:VALUE_WIDTH];
      quo <= '0;
      cnt <= LAST_STEP;
    end
    if (cmd.step) begin
      rem <= fits ? TIME_WIDTH'(trial - {1'b0, res}) : trial[TIME_WIDTH-1:0];
      quo <= {quo[VALUE_WIDTH-2:0], fits};
      cnt <= cnt - 1'b1;
    end
    if (cmd.finish) begin
      minimum_seen      <= OUT_WIDTH'(mn_next);
      maximum_seen      <= OUT_WIDTH'(mx_next);
      weighted_average  <= OUT_WIDTH'(avg_next);
      average_saturated <= sat_next;
    end
  end

endmodule

`default_nettype wire
